// ===== design/lrre_pkg.sv =====
// ----------------------------------------------------------------------------
// lrre_pkg
// Shared widths, register indexes, color mode codes, fixed-point constants and
// the command/status structs of the LED ring ripple core.
// ----------------------------------------------------------------------------
package lrre_pkg;

    // field widths
    localparam int SLOT_W     = 8;
    localparam int CHAN_W     = 8;
    localparam int MODE_W     = 3;
    localparam int INT_W      = 8;
    localparam int FRAME_W    = 6;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 32;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_COLOUR_MODE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RING_INTENSITY = 1'd1;

    // color modes; codes above MODE_GREEN behave as green
    localparam logic [MODE_W-1:0] MODE_BLUE    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RED     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MAGENTA = 3'd2;
    localparam logic [MODE_W-1:0] MODE_YELLOW  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_GREEN   = 3'd4;

    localparam logic [MODE_W-1:0] MODE_RESET   = MODE_BLUE;
    localparam logic [INT_W-1:0]  INTENS_RESET = 8'd255;

    // grid defaults
    localparam int DEF_GRID_WIDTH  = 16;
    localparam int DEF_GRID_HEIGHT = 16;

    // effect phases
    localparam int GROW_FRAMES = 14;
    localparam int FADE_FRAMES = 30;
    localparam int FRAME_MAX   = 63;
    localparam int DONE_FRAME  = (GROW_FRAMES + FADE_FRAMES > FRAME_MAX) ?
                                 FRAME_MAX : GROW_FRAMES + FADE_FRAMES;

    // fixed point: dist = isqrt(sq << 14) is Q8.8
    localparam int DIST_FRAC = 14;
    localparam int DIFF_W    = 16;
    localparam int RING_HALF = 128;
    localparam int RING_ONE  = 256;

    // c*92/100 == (c*120589) >> 17 for 8-bit c
    localparam int FADE_MUL = 120589;
    localparam int FADE_SH  = 17;
    // frame*768/5 == (frame*40265472) >> 18
    localparam int RAD_MUL  = 40265472;
    localparam int RAD_SH   = 18;
    localparam int RAD_W    = 14;
    // slot / GRID_WIDTH by reciprocal, 16 fraction bits
    localparam int YDIV_SH  = 16;

    // ring scale: full = ((w*13) >> 9) / 5, blue2 = ((w*39) >> 7) / 85
    localparam int FULL_MUL  = 13;
    localparam int FULL_SH   = 9;
    localparam int BLUE_MUL  = 39;
    localparam int BLUE_SH   = 7;
    localparam int DIV5_MUL  = 52429;
    localparam int DIV5_SH   = 18;
    localparam int DIV85_MUL = 24673;
    localparam int DIV85_SH  = 21;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic load_item;
        logic load_fade;
        logic load_map;
        logic load_sq;
        logic start_root;
        logic load_ring;
        logic load_scale;
        logic load_mix;
        logic load_out;
    } lrre_cmd_t;

    typedef struct packed {
        logic do_ring;
        logic root_busy;
        logic out_free;
    } lrre_stat_t;

endpackage

// ===== design/lrre_isqrt.sv =====
// ----------------------------------------------------------------------------
// lrre_isqrt
// Iterative floor integer square root, one result bit per clock.
// ----------------------------------------------------------------------------
module lrre_isqrt #(
    parameter int OPND_W = 23
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [OPND_W-1:0]          opnd,
    output logic                       busy,
    output logic [(OPND_W+1)/2-1:0]    root
);

    localparam int R_W   = (OPND_W + 1) / 2;
    localparam int PAD_W = 2 * R_W;
    localparam int CNT_W = $clog2(R_W + 1);

    logic [PAD_W-1:0] opnd_reg;
    logic [R_W-1:0]   rem_reg;
    logic [R_W-1:0]   root_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;

    logic [R_W+1:0]   rem_sh;
    logic [R_W+1:0]   trial;
    logic [R_W+1:0]   rem_sub;
    logic             take;

    // bring down the next two operand bits, try root*4+1
    assign rem_sh  = {rem_reg, opnd_reg[PAD_W-1 -: 2]};
    assign trial   = {root_reg, 2'b01};
    assign take    = (rem_sh >= trial);
    assign rem_sub = rem_sh - trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(R_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            opnd_reg <= PAD_W'(opnd);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            opnd_reg <= {opnd_reg[PAD_W-3:0], 2'b00};
            // partial remainder stays below 2^R_W until the last step
            rem_reg  <= take ? rem_sub[R_W-1:0] : rem_sh[R_W-1:0];
            root_reg <= {root_reg[R_W-2:0], take};
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

// ===== design/lrre_ctrl.sv =====
// ----------------------------------------------------------------------------
// lrre_ctrl
// Sequencer for one pixel read-modify-write: read, map, root, ring, mix, out.
// ----------------------------------------------------------------------------
module lrre_ctrl
    import lrre_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  lrre_stat_t stat,
    output lrre_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_READ    = 4'd1;
    localparam logic [3:0] S_MAP     = 4'd2;
    localparam logic [3:0] S_SQ      = 4'd3;
    localparam logic [3:0] S_ROOT_GO = 4'd4;
    localparam logic [3:0] S_ROOT    = 4'd5;
    localparam logic [3:0] S_RING    = 4'd6;
    localparam logic [3:0] S_SCALE   = 4'd7;
    localparam logic [3:0] S_MIX     = 4'd8;
    localparam logic [3:0] S_OUT     = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
                if (in_valid)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.load_fade = 1'b1;
                state_next    = stat.do_ring ? S_MAP : S_MIX;
            end
            S_MAP:
            begin
                cmd.load_map = 1'b1;
                state_next   = S_SQ;
            end
            S_SQ:
            begin
                cmd.load_sq = 1'b1;
                state_next  = S_ROOT_GO;
            end
            S_ROOT_GO:
            begin
                cmd.start_root = 1'b1;
                state_next     = S_ROOT;
            end
            S_ROOT:
            begin
                if (!stat.root_busy)
                begin
                    state_next = S_RING;
                end
            end
            S_RING:
            begin
                cmd.load_ring = 1'b1;
                state_next    = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.load_scale = 1'b1;
                state_next     = S_MIX;
            end
            S_MIX:
            begin
                cmd.load_mix = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/lrre_datapath.sv =====
// ----------------------------------------------------------------------------
// lrre_datapath
// Frame store, frame counter, config registers, pixel mapping, fade, ring
// test and scaling, output register.
// ----------------------------------------------------------------------------
module lrre_datapath
    import lrre_pkg::*;
#(
    parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
    parameter int GRID_HEIGHT = DEF_GRID_HEIGHT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lrre_cmd_t             cmd,
    output lrre_stat_t            stat,
    input  logic [SLOT_W-1:0]     in_slot,
    input  logic                  in_last,
    input  logic                  in_restart,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [M_TDATA_W-1:0]  out_data
);

    localparam int NUM_CELLS = GRID_WIDTH * GRID_HEIGHT;
    localparam int MEM_CELLS = (NUM_CELLS < 2**SLOT_W) ? NUM_CELLS : 2**SLOT_W;
    localparam int MEM_AW    = $clog2(MEM_CELLS);
    localparam int MEM_N     = 2**MEM_AW;
    localparam int X_W       = $clog2(GRID_WIDTH);
    localparam int Y_W       = $clog2(GRID_HEIGHT);
    localparam int TX_W      = X_W + 1;
    localparam int TY_W      = Y_W + 1;
    localparam int SQ_MAX    = (GRID_WIDTH - 1) * (GRID_WIDTH - 1) +
                               (GRID_HEIGHT - 1) * (GRID_HEIGHT - 1);
    localparam int SQ_W      = $clog2(SQ_MAX + 1);
    localparam int D_W       = SQ_W + DIST_FRAC;
    localparam int R_W       = (D_W + 1) / 2;
    localparam int Y_MUL     = (2**YDIV_SH + GRID_WIDTH - 1) / GRID_WIDTH;

    // ---------------- config registers ----------------
    logic [MODE_W-1:0] mode_reg;
    logic [INT_W-1:0]  intens_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_RESET;
            intens_reg <= INTENS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COLOUR_MODE:    mode_reg   <= cfg_data[MODE_W-1:0];
                REG_RING_INTENSITY: intens_reg <= cfg_data[INT_W-1:0];
            endcase
        end
    end

    // ---------------- item capture and frame counter ----------------
    logic [FRAME_W-1:0] frame_reg;
    logic [FRAME_W-1:0] frame_cur;
    logic [FRAME_W-1:0] frame_item_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic               in_grid;
    logic               in_grid_reg;
    logic               grow_reg;
    logic               fade_on_reg;
    logic [23:0]        y_prod;
    logic [SLOT_W-1:0]  yq_reg;

    assign frame_cur = in_restart ? '0 : frame_reg;
    assign in_grid   = ({24'd0, in_slot} < 32'(NUM_CELLS));
    assign y_prod    = 24'(in_slot) * 24'(Y_MUL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg <= '0;
        end
        else if (cmd.load_item)
        begin
            // advance after this slot, holding at the top
            if (in_last && (frame_cur != FRAME_W'(FRAME_MAX)))
            begin
                frame_reg <= frame_cur + 1'b1;
            end
            else
            begin
                frame_reg <= frame_cur;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            slot_reg       <= in_slot;
            frame_item_reg <= frame_cur;
            in_grid_reg    <= in_grid;
            grow_reg       <= (frame_cur < FRAME_W'(GROW_FRAMES));
            fade_on_reg    <= (frame_cur < FRAME_W'(DONE_FRAME));
            yq_reg         <= y_prod[YDIV_SH +: SLOT_W];
        end
    end

    // ---------------- frame store ----------------
    logic [23:0]       mem [MEM_N];
    logic [MEM_N-1:0]  valid_reg;
    logic [23:0]       rd_reg;
    logic              vld_rd_reg;
    logic [MEM_AW-1:0] raddr;
    logic [MEM_AW-1:0] waddr;
    logic              mem_we;
    rgb_t              mix_rgb;

    assign raddr  = in_slot[MEM_AW-1:0];
    assign waddr  = slot_reg[MEM_AW-1:0];
    assign mem_we = cmd.load_mix && in_grid_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= mix_rgb;
        end
        if (cmd.load_item)
        begin
            rd_reg <= mem[raddr];
        end
    end

    // entries never written read as black
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            vld_rd_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (cmd.load_item)
            begin
                vld_rd_reg <= valid_reg[raddr];
            end
        end
    end

    // ---------------- fade ----------------
    function automatic logic [CHAN_W-1:0] fade_chan(input logic [CHAN_W-1:0] c);
        logic [24:0] p;
        p = 25'(c) * 25'(FADE_MUL);
        return p[FADE_SH +: CHAN_W];
    endfunction

    rgb_t stored_rgb;
    rgb_t faded_rgb;
    rgb_t faded_reg;

    assign stored_rgb = vld_rd_reg ? rgb_t'(rd_reg) : '0;

    always_comb
    begin
        faded_rgb = stored_rgb;
        if (fade_on_reg)
        begin
            faded_rgb.red   = fade_chan(stored_rgb.red);
            faded_rgb.green = fade_chan(stored_rgb.green);
            faded_rgb.blue  = fade_chan(stored_rgb.blue);
        end
        if (!in_grid_reg)
        begin
            faded_rgb = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_fade)
        begin
            faded_reg <= faded_rgb;
        end
    end

    // ---------------- slot to x,y and center offsets ----------------
    logic [SLOT_W-1:0] xw8;
    logic [X_W-1:0]    xw;
    logic [X_W-1:0]    xr;
    logic [Y_W-1:0]    yr;
    logic [TX_W-1:0]   tx;
    logic [TY_W-1:0]   ty;
    logic [TX_W-1:0]   adx_w;
    logic [TY_W-1:0]   ady_w;
    logic [X_W-1:0]    adx_reg;
    logic [Y_W-1:0]    ady_reg;
    logic [31:0]       rad_prod;
    logic [RAD_W-1:0]  rad_reg;

    assign xw8 = slot_reg - SLOT_W'(16'(yq_reg) * 16'(GRID_WIDTH));
    assign xw  = xw8[X_W-1:0];
    // odd rows run right to left
    assign xr  = yq_reg[0] ? (X_W'(GRID_WIDTH - 1) - xw) : xw;
    assign yr  = yq_reg[Y_W-1:0];
    assign tx  = {xr, 1'b0};
    assign ty  = {yr, 1'b0};
    assign adx_w = (tx >= TX_W'(GRID_WIDTH - 1)) ? (tx - TX_W'(GRID_WIDTH - 1)) :
                                                   (TX_W'(GRID_WIDTH - 1) - tx);
    assign ady_w = (ty >= TY_W'(GRID_HEIGHT - 1)) ? (ty - TY_W'(GRID_HEIGHT - 1)) :
                                                    (TY_W'(GRID_HEIGHT - 1) - ty);
    assign rad_prod = 32'(frame_item_reg) * 32'(RAD_MUL);

    always_ff @(posedge clk)
    begin
        if (cmd.load_map)
        begin
            adx_reg <= adx_w[X_W-1:0];
            ady_reg <= ady_w[Y_W-1:0];
            rad_reg <= rad_prod[RAD_SH +: RAD_W];
        end
    end

    // ---------------- squared distance and root ----------------
    logic [SQ_W-1:0] sq_reg;
    logic [R_W-1:0]  root;
    logic            root_busy;

    always_ff @(posedge clk)
    begin
        if (cmd.load_sq)
        begin
            sq_reg <= SQ_W'(adx_reg) * SQ_W'(adx_reg) + SQ_W'(ady_reg) * SQ_W'(ady_reg);
        end
    end

    lrre_isqrt #(
        .OPND_W (D_W)
    ) u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.start_root),
        .opnd  ({sq_reg, {DIST_FRAC{1'b0}}}),
        .busy  (root_busy),
        .root  (root)
    );

    // ---------------- ring test and weight ----------------
    logic [DIFF_W-1:0] dist16;
    logic [DIFF_W-1:0] rad16;
    logic [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0] w16;
    logic              hit_reg;
    logic [15:0]       wi_reg;

    assign dist16 = DIFF_W'(root);
    assign rad16  = DIFF_W'(rad_reg);
    assign diff   = (dist16 > rad16) ? (dist16 - rad16) : (rad16 - dist16);
    assign w16    = DIFF_W'(RING_ONE) - diff;

    always_ff @(posedge clk)
    begin
        if (cmd.load_ring)
        begin
            hit_reg <= (diff < DIFF_W'(RING_HALF));
            // weight is at most 256 when on the ring
            wi_reg  <= 16'(w16[8:0]) * 16'(intens_reg);
        end
    end

    // ---------------- scaling ----------------
    logic [19:0] full_prod;
    logic [21:0] blue_prod;
    logic [10:0] v1_reg;
    logic [14:0] v2_reg;

    assign full_prod = 20'(wi_reg) * 20'(FULL_MUL);
    assign blue_prod = 22'(wi_reg) * 22'(BLUE_MUL);

    always_ff @(posedge clk)
    begin
        if (cmd.load_scale)
        begin
            v1_reg <= full_prod[FULL_SH +: 11];
            v2_reg <= blue_prod[BLUE_SH +: 15];
        end
    end

    // ---------------- mix ----------------
    logic [26:0]       q1_prod;
    logic [28:0]       q2_prod;
    logic [8:0]        q1;
    logic [CHAN_W-1:0] full;
    logic [CHAN_W-1:0] blue2;
    rgb_t              ring_rgb;
    rgb_t              res_reg;

    assign q1_prod = 27'(v1_reg) * 27'(DIV5_MUL);
    assign q2_prod = 29'(v2_reg) * 29'(DIV85_MUL);
    assign q1      = q1_prod[DIV5_SH +: 9];
    assign full    = q1[8] ? 8'hFF : q1[7:0];
    // 180/255 of full scale stays below 255
    assign blue2   = q2_prod[DIV85_SH +: CHAN_W];

    always_comb
    begin
        ring_rgb = '0;
        case (mode_reg)
            MODE_BLUE:
            begin
                ring_rgb.blue = full;
            end
            MODE_RED:
            begin
                ring_rgb.red = full;
            end
            MODE_MAGENTA:
            begin
                ring_rgb.red  = full;
                ring_rgb.blue = blue2;
            end
            MODE_YELLOW:
            begin
                ring_rgb.red   = full;
                ring_rgb.green = full;
            end
            default:
            begin
                ring_rgb.green = full;
            end
        endcase
    end

    assign mix_rgb = (in_grid_reg && grow_reg && hit_reg) ? ring_rgb : faded_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_mix)
        begin
            res_reg <= mix_rgb;
        end
    end

    // ---------------- output register ----------------
    logic  out_valid_reg;
    rgb_t  out_rgb_reg;
    logic  out_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_rgb_reg  <= res_reg;
            out_done_reg <= !fade_on_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {7'd0, out_done_reg, out_rgb_reg.blue,
                        out_rgb_reg.green, out_rgb_reg.red};

    assign stat.do_ring   = in_grid_reg && grow_reg;
    assign stat.root_busy = root_busy;
    assign stat.out_free  = !out_valid_reg || out_ready;

`ifndef ASSERT_OFF
    a_root_ring_only: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_root |-> (in_grid_reg && grow_reg))
        else $error("root started for a pixel off the ring path");

    a_ring_after_root: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_ring |-> !root_busy)
        else $error("ring test sampled a root still in progress");

    a_out_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !cmd.load_out)
        else $error("output register overwritten while held");

    a_frame_only_on_item: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.load_item |=> $stable(frame_reg))
        else $error("frame counter moved without an input beat");
`endif

endmodule

// ===== design/led_ring_ripple_effect_core.sv =====
// ----------------------------------------------------------------------------
// led_ring_ripple_effect_core
// Ripple ring effect on a serpentine-wired RGB LED grid, one pixel per beat.
// ----------------------------------------------------------------------------
// Each input beat names one LED slot (wire order, even rows left to right,
// odd rows right to left) and returns one output beat with its new color.
// The stored color is faded to floor(c*92/100) per channel while the effect
// runs; during the first 14 frames a pixel within half a pixel of the growing
// ring (radius 0.6 px per frame, distance in Q8.8) is replaced by the ring
// color scaled by ring_intensity, with a 1.3 gain saturating at 255. After
// 30 more fade frames colors pass unchanged and effect_done reads 1. tlast
// on a beat advances the frame counter after that pixel; restart clears it
// first. Slots beyond the grid return black and touch no store entry.
// Items are processed one at a time. A pixel that needs no ring test goes
// through read, mix and out; during growth frames an in-grid pixel also
// takes map, square, the iterative square root (one distance bit per
// cycle, root width 12 for a 16x16 grid), ring and scale before mix. The
// next beat is taken in the cycle after the result is loaded into the
// output register, so it is taken while a finished result waits there. The
// frame store comes out of reset black through per-entry valid bits, with
// no clearing pass.
// Configuration (color mode, ring intensity) is to be written by the user
// only while idle; the core itself does not enforce this.
// ----------------------------------------------------------------------------
module led_ring_ripple_effect_core
    import lrre_pkg::*;
#(
    parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
    parameter int GRID_HEIGHT = DEF_GRID_HEIGHT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // input pixel beats
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] led_slot, [8] restart
    input  logic                  s_tlast,   // frame_end
    // output pixel beats
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [7:0] red, [15:8] green,
                                             // [23:16] blue, [24] effect_done
    // configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    lrre_cmd_t  cmd;
    lrre_stat_t stat;

    lrre_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lrre_datapath #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_slot    (s_tdata[SLOT_W-1:0]),
        .in_last    (s_tlast),
        .in_restart (s_tdata[SLOT_W]),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_data   (m_tdata)
    );

endmodule
